>>> sv/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/qrs_pkg.sv
// Types and constants for the quadratic root solver.
// No dependencies; imported by every solver module.
package qrs_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 34;

    localparam logic [1:0] REG_COEFF_TOL = 2'd0;
    localparam logic [1:0] REG_DISC_TOL  = 2'd1;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_ONE  = 2'd1,
        ST_TWO  = 2'd2,
        ST_INF  = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic signed [34:0] nb;
        logic signed [15:0] den;
        logic [63:0]        rad;
        logic [33:0]        rem;
        logic [31:0]        root;
    } sq_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] ud;
        logic [33:0] un1;
        logic [33:0] un2;
        logic [33:0] q1;
        logic [33:0] q2;
        logic [15:0] rem1;
        logic [15:0] rem2;
        logic        neg1;
        logic        neg2;
    } div_t;

endpackage

>>> sv/qrs_front.sv
// Front end: input capture, coefficient products, discriminant and case decode.
// Depends on qrs_pkg; feeds the square-root cell chain.
module qrs_front
    import qrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    input  logic signed [15:0] c,
    input  logic [14:0]        coeff_tol,
    input  logic [31:0]        disc_tol,
    output logic               out_vld,
    output sq_t                out_data
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [15:0] a1_reg, b1_reg, c1_reg;
    logic signed [15:0] a2_reg, b2_reg, c2_reg;
    logic signed [31:0] bb_reg, ac_reg;
    sq_t                s3_reg;
    sq_t                s3_next;

    logic signed [34:0] d;
    logic [34:0]        d_mag;
    logic [15:0]        a_mag, b_mag, c_mag;
    logic               lin, b_small, c_small, d_zero;

    always_comb
    begin
        a_mag   = a2_reg[15] ? 16'(-a2_reg) : 16'(a2_reg);
        b_mag   = b2_reg[15] ? 16'(-b2_reg) : 16'(b2_reg);
        c_mag   = c2_reg[15] ? 16'(-c2_reg) : 16'(c2_reg);
        lin     = a_mag <= {1'b0, coeff_tol};
        b_small = b_mag <= {1'b0, coeff_tol};
        c_small = c_mag <= {1'b0, coeff_tol};
        d       = $signed({{3{bb_reg[31]}}, bb_reg}) - $signed({ac_reg[31], ac_reg, 2'b00});
        d_mag   = d[34] ? 35'(-d) : 35'(d);
        d_zero  = d_mag <= {3'b000, disc_tol};

        s3_next.rem  = '0;
        s3_next.root = '0;
        s3_next.rad  = '0;
        if (lin)
        begin
            s3_next.status = b_small ? (c_small ? ST_INF : ST_NONE) : ST_ONE;
            s3_next.nb     = -$signed({{3{c2_reg[15]}}, c2_reg, 16'h0000});
            s3_next.den    = b2_reg;
        end
        else
        begin
            s3_next.status = d_zero ? ST_ONE : (d[34] ? ST_NONE : ST_TWO);
            s3_next.nb     = -$signed({{4{b2_reg[15]}}, b2_reg, 15'h0000});
            s3_next.den    = a2_reg;
            if (!d_zero && !d[34])
                s3_next.rad = {d[33:0], 30'h0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a;
            b1_reg <= b;
            c1_reg <= c;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
            bb_reg <= b1_reg * b1_reg;
            ac_reg <= a1_reg * c1_reg;
            s3_reg <= s3_next;
        end
    end

    assign out_vld  = v3_reg;
    assign out_data = s3_reg;

endmodule

>>> sv/qrs_sqrt_cell.sv
// One square-root cell: one root bit per enabled cycle, two radicand bits in.
// Depends on qrs_pkg.
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  sq_t  in_data,
    output logic out_vld,
    output sq_t  out_data
);

    logic        vld_reg;
    sq_t         data_reg;
    sq_t         data_next;
    logic [35:0] rem_t, trial, diff;
    logic        ge;

    always_comb
    begin
        rem_t          = {in_data.rem, in_data.rad[63:62]};
        trial          = {2'b00, in_data.root, 2'b01};
        diff           = rem_t - trial;
        ge             = rem_t >= trial;
        data_next      = in_data;
        data_next.rad  = {in_data.rad[61:0], 2'b00};
        data_next.rem  = ge ? diff[33:0] : rem_t[33:0];
        data_next.root = {in_data.root[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

>>> sv/qrs_div_cell.sv
// One divider cell: one restoring quotient bit per enabled cycle, both lanes.
// Depends on qrs_pkg.
module qrs_div_cell
    import qrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  div_t in_data,
    output logic out_vld,
    output div_t out_data
);

    logic        vld_reg;
    div_t        data_reg;
    div_t        data_next;
    logic [16:0] rt1, rt2, df1, df2;
    logic        ge1, ge2;

    always_comb
    begin
        rt1 = {in_data.rem1, in_data.un1[33]};
        rt2 = {in_data.rem2, in_data.un2[33]};
        df1 = rt1 - {1'b0, in_data.ud};
        df2 = rt2 - {1'b0, in_data.ud};
        ge1 = rt1 >= {1'b0, in_data.ud};
        ge2 = rt2 >= {1'b0, in_data.ud};
        data_next      = in_data;
        data_next.un1  = {in_data.un1[32:0], 1'b0};
        data_next.un2  = {in_data.un2[32:0], 1'b0};
        data_next.rem1 = ge1 ? df1[15:0] : rt1[15:0];
        data_next.rem2 = ge2 ? df2[15:0] : rt2[15:0];
        data_next.q1   = {in_data.q1[32:0], ge1};
        data_next.q2   = {in_data.q2[32:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

>>> sv/quadratic_root_solver_top.sv
// Quadratic root solver: Q8.8 coefficients in, ascending Q16.16 roots out.
// One input transfer per cycle while in_stall is low.
// The chain has 32 square-root cells and 34 divider cells.
// The whole chain holds while a result waits under stall; async reset clears
// valid bits and both tolerances to zero. Depends on qrs_pkg and the cells.
`include "assert_macros.svh"
module quadratic_root_solver_top
    import qrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] root_low,
    output logic signed [31:0] root_high,
    output logic               saturated
);

    logic [14:0] coeff_tol_reg;
    logic [31:0] disc_tol_reg;
    logic        en;

    logic        sq_vld [0:SQ_STEPS];
    sq_t         sq_dat [0:SQ_STEPS];
    logic        dv_vld [0:DIV_STEPS];
    div_t        dv_dat [0:DIV_STEPS];

    logic               x_vld_reg, f_vld_reg, o_vld_reg;
    status_t            x_status_reg, f_status_reg, o_status_reg;
    logic signed [34:0] n1_reg, n2_reg;
    logic signed [15:0] x_den_reg;
    div_t               y_next;
    logic [34:0]        m1, m2;
    logic signed [31:0] r1, r2, r1_reg, r2_reg;
    logic               s1, s2, f_sat_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic               o_sat_reg;

    assign en       = !(o_vld_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_tol_reg <= '0;
            disc_tol_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COEFF_TOL)
                coeff_tol_reg <= cfg_data[14:0];
            else if (cfg_index == REG_DISC_TOL)
                disc_tol_reg <= cfg_data;
        end
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .a         (coef_a),
        .b         (coef_b),
        .c         (coef_c),
        .coeff_tol (coeff_tol_reg),
        .disc_tol  (disc_tol_reg),
        .out_vld   (sq_vld[0]),
        .out_data  (sq_dat[0])
    );

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (sq_vld[i]),
            .in_data  (sq_dat[i]),
            .out_vld  (sq_vld[i+1]),
            .out_data (sq_dat[i+1])
        );
    end

    // nb +/- square root term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg       <= sq_dat[SQ_STEPS].nb - $signed({3'b000, sq_dat[SQ_STEPS].root});
            n2_reg       <= sq_dat[SQ_STEPS].nb + $signed({3'b000, sq_dat[SQ_STEPS].root});
            x_den_reg    <= sq_dat[SQ_STEPS].den;
            x_status_reg <= sq_dat[SQ_STEPS].status;
        end
    end

    // magnitudes plus half divisor for round to nearest
    always_comb
    begin
        m1            = n1_reg[34] ? 35'(-n1_reg) : 35'(n1_reg);
        m2            = n2_reg[34] ? 35'(-n2_reg) : 35'(n2_reg);
        y_next.status = x_status_reg;
        y_next.ud     = x_den_reg[15] ? 16'(-x_den_reg) : 16'(x_den_reg);
        y_next.un1    = m1[33:0] + {19'h0, y_next.ud[15:1]};
        y_next.un2    = m2[33:0] + {19'h0, y_next.ud[15:1]};
        y_next.q1     = '0;
        y_next.q2     = '0;
        y_next.rem1   = '0;
        y_next.rem2   = '0;
        y_next.neg1   = n1_reg[34] ^ x_den_reg[15];
        y_next.neg2   = n2_reg[34] ^ x_den_reg[15];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_dat[0] <= y_next;
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (dv_vld[j]),
            .in_data  (dv_dat[j]),
            .out_vld  (dv_vld[j+1]),
            .out_data (dv_dat[j+1])
        );
    end

    always_comb
    begin
        s1 = dv_dat[DIV_STEPS].neg1 ? (dv_dat[DIV_STEPS].q1 > 34'h0_8000_0000)
                                    : (dv_dat[DIV_STEPS].q1 > 34'h0_7FFF_FFFF);
        s2 = dv_dat[DIV_STEPS].neg2 ? (dv_dat[DIV_STEPS].q2 > 34'h0_8000_0000)
                                    : (dv_dat[DIV_STEPS].q2 > 34'h0_7FFF_FFFF);
        if (dv_dat[DIV_STEPS].neg1)
            r1 = s1 ? 32'sh8000_0000 : -$signed(dv_dat[DIV_STEPS].q1[31:0]);
        else
            r1 = s1 ? 32'sh7FFF_FFFF : $signed(dv_dat[DIV_STEPS].q1[31:0]);
        if (dv_dat[DIV_STEPS].neg2)
            r2 = s2 ? 32'sh8000_0000 : -$signed(dv_dat[DIV_STEPS].q2[31:0]);
        else
            r2 = s2 ? 32'sh7FFF_FFFF : $signed(dv_dat[DIV_STEPS].q2[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_status_reg <= dv_dat[DIV_STEPS].status;
            if (dv_dat[DIV_STEPS].status == ST_ONE || dv_dat[DIV_STEPS].status == ST_TWO)
            begin
                r1_reg    <= r1;
                r2_reg    <= r2;
                f_sat_reg <= s1 || s2;
            end
            else
            begin
                r1_reg    <= '0;
                r2_reg    <= '0;
                f_sat_reg <= 1'b0;
            end
            o_status_reg <= f_status_reg;
            o_sat_reg    <= f_sat_reg;
            lo_reg       <= (r1_reg < r2_reg) ? r1_reg : r2_reg;
            hi_reg       <= (r1_reg < r2_reg) ? r2_reg : r1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_vld_reg <= 1'b0;
            dv_vld[0] <= 1'b0;
            f_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            x_vld_reg <= sq_vld[SQ_STEPS];
            dv_vld[0] <= x_vld_reg;
            f_vld_reg <= dv_vld[DIV_STEPS];
            o_vld_reg <= f_vld_reg;
        end
    end

    assign out_valid = o_vld_reg;
    assign status    = o_status_reg;
    assign root_low  = lo_reg;
    assign root_high = hi_reg;
    assign saturated = o_sat_reg;

    `ASSERT_IMPLIES(a_absent_zero, clk, rst_n, out_valid && (status == ST_NONE || status == ST_INF), root_low == 32'sd0 && root_high == 32'sd0 && !saturated)
    `ASSERT_IMPLIES(a_one_equal, clk, rst_n, out_valid && status == ST_ONE, root_low == root_high)
    `ASSERT_IMPLIES(a_two_order, clk, rst_n, out_valid && status == ST_TWO, root_low <= root_high)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, in_stall, out_valid)

endmodule
